FILE: rtl/vbc_pkg.sv
`default_nettype none

package vbc_pkg;

    typedef struct packed {
        logic       operation;
        logic [5:0] pos_x;
        logic [5:0] pos_y;
        logic [5:0] pos_z;
        logic [7:0] voxel_value;
    } t_in_item;

    typedef struct packed {
        logic        is_contour;
        logic        is_mask;
        logic [12:0] neighbour_sum;
        logic        out_of_range;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTRE,
        S_CHECK,
        S_SUM,
        S_LAST
    } t_state;

    localparam logic OP_WRITE    = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [6:0] SIZE_RESET = 7'd64;

    localparam int unsigned MASK_VALUE = 1;
    localparam int unsigned NEIGHBOURS = 27;
    localparam int unsigned SUM_MAX    = 8191;

    // neighbourhood offsets run 0..2 on each axis
    localparam logic [1:0] OFS_LAST = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/vbc_ram.sv
`default_nettype none

module vbc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 262144
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/volume_boundary_voxel_classifier_top.sv
`default_nettype none

// voxel volume with 3x3x3 boundary classification
//
// items enter on i_item when start is high and busy is low. a write item
// (operation 0) stores its value in the volume at the accepting edge if it
// lies inside the grid, and gives no result; the block stays ready, so
// writes go at one per cycle. a classify item (operation 1) raises busy and
// gives exactly one result, shown on o_result for a single cycle with o_result_valid high:
//   outside the grid            from the centre state
//   non-mask or face voxel      from the check state, after the centre read
//   interior mask voxel         after the sum and last states (27 neighbourhood reads)
// the volume sits in one single-port memory with a registered read, so the
// neighbourhood is read one voxel per cycle into a single accumulator.
// busy drops in the cycle the result appears, and a new item may be taken
// then. the receiver cannot stall: each result beat is taken as shown.
// the user must write the size registers on the cfg port only while busy
// is low; the block does not enforce it. reset sets all extents to 64 and
// returns the sequencer to idle; the volume itself is not cleared, and
// reads of unwritten voxels are undefined, so no clearing pass is run.

module volume_boundary_voxel_classifier_top
    import vbc_pkg::*;
#(
    parameter int unsigned MAX_EXTENT = 64,
    parameter int unsigned VALUE_BITS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data,
    input  wire logic       start,
    input  wire t_in_item   i_item,
    output logic            busy,
    output logic            o_result_valid,
    output t_out_item       o_result
);

    localparam int unsigned DEPTH = MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;
    localparam int unsigned PLANE = MAX_EXTENT * MAX_EXTENT;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned SW    = VALUE_BITS + 5;
    localparam logic [8:0]  MAX_EXT_9 = 9'(MAX_EXTENT);

    logic [6:0] r_size_x, r_size_y, r_size_z;
    logic [6:0] eff_x, eff_y, eff_z;

    t_state     r_state, n_state;
    logic [5:0] r_x, r_y, r_z;
    logic       r_inside, r_face;
    logic       in_inside, in_face;
    logic [1:0] r_dx, r_dy, r_dz, n_dx, n_dy, n_dz;
    logic       r_acc_en;
    logic [SW-1:0] r_sum;
    logic [SW-1:0] sum_total;

    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;

    logic [5:0] sel_x, sel_y, sel_z;
    logic [AW-1:0] ram_addr;
    logic       ram_we;
    logic [VALUE_BITS-1:0] ram_rdata;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // extents limited to the store size
    assign eff_x = ({2'b00, r_size_x} > MAX_EXT_9) ? MAX_EXT_9[6:0] : r_size_x;
    assign eff_y = ({2'b00, r_size_y} > MAX_EXT_9) ? MAX_EXT_9[6:0] : r_size_y;
    assign eff_z = ({2'b00, r_size_z} > MAX_EXT_9) ? MAX_EXT_9[6:0] : r_size_z;

    assign in_inside = ({1'b0, i_item.pos_x} < eff_x) && ({1'b0, i_item.pos_y} < eff_y)
                    && ({1'b0, i_item.pos_z} < eff_z);
    assign in_face = (i_item.pos_x == 6'd0) || (i_item.pos_y == 6'd0)
                  || (i_item.pos_z == 6'd0)
                  || ({1'b0, i_item.pos_x} == eff_x - 7'd1)
                  || ({1'b0, i_item.pos_y} == eff_y - 7'd1)
                  || ({1'b0, i_item.pos_z} == eff_z - 7'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_acc_en    <= 1'b0;
            r_dx        <= '0;
            r_dy        <= '0;
            r_dz        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_acc_en    <= (r_state == S_SUM);
            r_dx        <= n_dx;
            r_dy        <= n_dy;
            r_dz        <= n_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == S_IDLE) begin
            r_x      <= i_item.pos_x;
            r_y      <= i_item.pos_y;
            r_z      <= i_item.pos_z;
            r_inside <= in_inside;
            r_face   <= in_face;
        end
    end

    // shared accumulator, one neighbour per cycle
    assign sum_total = r_sum + SW'(ram_rdata);

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_sum <= '0;
        end else if (r_acc_en) begin
            r_sum <= sum_total;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = 1'b0;
        n_out       = r_out;
        ram_we      = 1'b0;
        sel_x       = i_item.pos_x;
        sel_y       = i_item.pos_y;
        sel_z       = i_item.pos_z;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_dz        = r_dz;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.operation == OP_WRITE) begin
                        ram_we = in_inside;
                    end else begin
                        n_state = S_CENTRE;
                    end
                end
            end
            S_CENTRE: begin
                sel_x = r_x;
                sel_y = r_y;
                sel_z = r_z;
                if (!r_inside) begin
                    n_out_valid         = 1'b1;
                    n_out.is_contour    = 1'b0;
                    n_out.is_mask       = 1'b0;
                    n_out.neighbour_sum = '0;
                    n_out.out_of_range  = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_out.neighbour_sum = '0;
                n_out.out_of_range  = 1'b0;
                if (ram_rdata != VALUE_BITS'(MASK_VALUE)) begin
                    n_out_valid      = 1'b1;
                    n_out.is_contour = 1'b0;
                    n_out.is_mask    = 1'b0;
                    n_state          = S_IDLE;
                end else if (r_face) begin
                    n_out_valid      = 1'b1;
                    n_out.is_contour = 1'b1;
                    n_out.is_mask    = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_dx    = '0;
                    n_dy    = '0;
                    n_dz    = '0;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                // interior voxel, so every neighbour lies inside the grid
                sel_x = r_x + 6'(r_dx) - 6'd1;
                sel_y = r_y + 6'(r_dy) - 6'd1;
                sel_z = r_z + 6'(r_dz) - 6'd1;
                if (r_dz == OFS_LAST) begin
                    n_dz = '0;
                    if (r_dy == OFS_LAST) begin
                        n_dy = '0;
                        n_dx = r_dx + 2'd1;
                    end else begin
                        n_dy = r_dy + 2'd1;
                    end
                end else begin
                    n_dz = r_dz + 2'd1;
                end
                if (r_dx == OFS_LAST && r_dy == OFS_LAST && r_dz == OFS_LAST) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_out_valid         = 1'b1;
                n_out.is_mask       = 1'b1;
                n_out.out_of_range  = 1'b0;
                n_out.is_contour    = (32'(sum_total) != NEIGHBOURS);
                n_out.neighbour_sum = (32'(sum_total) > SUM_MAX) ? 13'(SUM_MAX)
                                                                 : 13'(sum_total);
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // one address unit shared by writes, centre and neighbour reads
    assign ram_addr = AW'(sel_x) * AW'(PLANE) + AW'(sel_y) * AW'(MAX_EXTENT) + AW'(sel_z);

    vbc_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(VALUE_BITS'(i_item.voxel_value)),
        .o_rdata(ram_rdata)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

`default_nettype wire

FILE: rtl/vbc_checker.sv
`default_nettype none

module vbc_checker
    import vbc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_busy,
    input wire logic      i_result_valid,
    input wire t_out_item i_result
);

    // a classify always passes through the centre state before its result, so beats never abut
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid |=> !i_result_valid)
        else $error("result beats in consecutive cycles");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid |-> $past(i_busy))
        else $error("result without a classify in progress");

    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(i_busy) && $past(i_rst_n)) |-> i_result_valid)
        else $error("classify ended without a result");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_result_valid && i_result.out_of_range) |->
            (!i_result.is_contour && !i_result.is_mask && i_result.neighbour_sum == 13'd0))
        else $error("out of range result carries data");

    a_nonmask_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_result_valid && !i_result.is_mask) |->
            (!i_result.is_contour && i_result.neighbour_sum == 13'd0))
        else $error("non-mask voxel flagged or summed");

endmodule

bind volume_boundary_voxel_classifier_top vbc_checker u_vbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_busy        (busy),
    .i_result_valid(o_result_valid),
    .i_result      (o_result)
);

`default_nettype wire
